// File: hw/rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Types, constants and lookup functions shared by the month calendar grid.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int GRID_ROWS   = 6;
    localparam int GRID_COLS   = 7;
    localparam int GRID_CELLS  = GRID_ROWS * GRID_COLS;
    localparam int QUEUE_DEPTH = 2;

    // month codes
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

    // reciprocals: x / 25 = (x * RECIP25) >> RECIP25_SHIFT for x < 4200
    localparam logic [10:0] RECIP25       = 11'd1311;
    localparam int          RECIP25_SHIFT = 15;
    // x / 7 = (x * RECIP7) >> RECIP7_SHIFT for x < 32768
    localparam logic [15:0] RECIP7        = 16'd37450;
    localparam int          RECIP7_SHIFT  = 18;

    localparam logic [14:0] YEAR_SHIFT = 15'd400;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month_number;
    } mcg_req_t;

    typedef struct packed {
        logic [2:0] grid_row;
        logic [2:0] grid_column;
        logic [4:0] day_of_month;
        logic       last_cell;
    } mcg_grid_t;

    // job descriptor from front to back
    typedef struct packed {
        logic [2:0] first_col;
        logic [4:0] month_len;
    } mcg_desc_t;

    // floor(3 * (mm + 1) / 5) for shifted month mm in 3..14
    function automatic logic [3:0] mcg_month_term(input logic [3:0] mm);
        logic [3:0] t;
        unique case (mm)
            4'd3:    t = 4'd2;
            4'd4:    t = 4'd3;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd4;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd6;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd7;
            4'd12:   t = 4'd7;
            4'd13:   t = 4'd8;
            4'd14:   t = 4'd9;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] mcg_month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/month_calendar_grid.sv
// ----------------------------------------------------------------------------
// month_calendar_grid
// Gregorian month calendar as a six-row, Sunday-first grid of 42 cells.
// ----------------------------------------------------------------------------
// Path: a request beat passes 3 front pipeline stages, the queue, the descriptor
// load and the output register before its first cell beat.
// Throughput: one cell beat per cycle from the back end's cell counter while grid_stall
// is low, 42 cells per request; the front accepts up to QUEUE_DEPTH+3 requests ahead.
// Reset: clears valid flags, queue pointers and counters; no memory clear.
module month_calendar_grid #(
    parameter int QUEUE_DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  mcg_pkg::mcg_req_t  req,
    output logic               grid_valid,
    input  logic               grid_stall,
    output mcg_pkg::mcg_grid_t grid
);

    logic               push_valid, push_ready;
    mcg_pkg::mcg_desc_t push_desc;
    logic               pop_valid, pop;
    mcg_pkg::mcg_desc_t pop_desc;

    mcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    mcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    mcg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc),
        .grid_valid (grid_valid),
        .grid_stall (grid_stall),
        .grid       (grid)
    );

endmodule

// File: hw/rtl/mcg_queue.sv
// ----------------------------------------------------------------------------
// mcg_queue
// Small FIFO of job descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module mcg_queue #(
    parameter int DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mcg_pkg::mcg_desc_t push_desc,
    output logic              pop_valid,
    input  logic              pop,
    output mcg_pkg::mcg_desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mcg_pkg::mcg_desc_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: hw/rtl/mcg_front.sv
// ----------------------------------------------------------------------------
// mcg_front
// Accepts requests and works out month length and first-day column in a
// three-stage pipeline (divide by 100/400 and by 7 via reciprocals).
// ----------------------------------------------------------------------------
module mcg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mcg_pkg::mcg_req_t req,
    output logic              push_valid,
    input  logic              push_ready,
    output mcg_pkg::mcg_desc_t push_desc
);

    logic advance;

    // stage 1 inputs
    logic        early;
    logic        month_ok;
    logic [14:0] yy;
    logic [3:0]  mm;
    logic [12:0] yy4;
    logic [11:0] y4;
    logic [23:0] prod_yy;
    logic [22:0] prod_y;

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic [3:0]  s1_month_reg;
    logic [14:0] s1_yy_reg;
    logic [3:0]  s1_mm_reg;
    logic [7:0]  s1_q100_reg;
    logic [1:0]  s1_year_lo_reg;
    logic [11:0] s1_y4_reg;
    logic [7:0]  s1_q25y_reg;

    // stage 2
    logic [15:0] sum;
    logic [7:0]  q400;
    logic [11:0] rem25;
    logic        div4, div100, div400, leap;
    logic [4:0]  len;

    logic        s2_valid_reg;
    logic        s2_ok_reg;
    logic [14:0] s2_sum_reg;
    logic [4:0]  s2_len_reg;
    logic [30:0] prod7;

    // stage 3
    logic        s3_valid_reg;
    logic        s3_ok_reg;
    logic [14:0] s3_sum_reg;
    logic [4:0]  s3_len_reg;
    logic [11:0] s3_q7_reg;
    logic [14:0] r7;

    assign advance   = !s3_valid_reg || push_ready;
    assign req_stall = !advance;

    always_comb
    begin
        month_ok = (req.month_number >= mcg_pkg::MONTH_JAN) &&
                   (req.month_number <= mcg_pkg::MONTH_DEC);
        early    = (req.month_number <= mcg_pkg::MONTH_FEB);
        // Jan/Feb count as months 13/14 of the prior year
        yy  = 15'(req.year) + mcg_pkg::YEAR_SHIFT - (early ? 15'd1 : 15'd0);
        mm  = early ? req.month_number + mcg_pkg::MONTHS_PER_YEAR : req.month_number;
        yy4 = yy[14:2];
        y4  = req.year[13:2];
        prod_yy = 24'(yy4) * 24'(mcg_pkg::RECIP25);
        prod_y  = 23'(y4) * 23'(mcg_pkg::RECIP25);
    end

    always_comb
    begin
        q400  = {2'b00, s1_q100_reg[7:2]};
        // +1 beyond the formula folds in the Monday-to-Sunday column shift
        sum   = 16'd2 + {11'd0, s1_mm_reg, 1'b0} + 16'(mcg_pkg::mcg_month_term(s1_mm_reg))
              + 16'(s1_yy_reg) + 16'(s1_yy_reg[14:2]) - 16'(s1_q100_reg) + 16'(q400);
        rem25  = s1_y4_reg - (12'(s1_q25y_reg) * 12'd25);
        div4   = (s1_year_lo_reg == 2'd0);
        div100 = div4 && (rem25 == 12'd0);
        div400 = div100 && (s1_q25y_reg[1:0] == 2'd0);
        leap   = (div4 && !div100) || div400;
        len    = s1_ok_reg ? mcg_pkg::mcg_month_days(s1_month_reg, leap) : 5'd0;
    end

    assign prod7 = 31'(s2_sum_reg) * 31'(mcg_pkg::RECIP7);

    always_comb
    begin
        r7 = s3_sum_reg - 15'({s3_q7_reg, 3'b000} - {3'b000, s3_q7_reg});
        push_desc.first_col = s3_ok_reg ? r7[2:0] : 3'd0;
        push_desc.month_len = s3_len_reg;
    end

    assign push_valid = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ok_reg      <= month_ok;
            s1_month_reg   <= req.month_number;
            s1_yy_reg      <= yy;
            s1_mm_reg      <= mm;
            s1_q100_reg    <= prod_yy[mcg_pkg::RECIP25_SHIFT +: 8];
            s1_year_lo_reg <= req.year[1:0];
            s1_y4_reg      <= y4;
            s1_q25y_reg    <= prod_y[mcg_pkg::RECIP25_SHIFT +: 8];

            s2_ok_reg      <= s1_ok_reg;
            s2_sum_reg     <= sum[14:0];
            s2_len_reg     <= len;

            s3_ok_reg      <= s2_ok_reg;
            s3_sum_reg     <= s2_sum_reg;
            s3_len_reg     <= s2_len_reg;
            s3_q7_reg      <= prod7[mcg_pkg::RECIP7_SHIFT +: 12];
        end
    end

endmodule

// File: hw/rtl/mcg_back.sv
// ----------------------------------------------------------------------------
// mcg_back
// Walks the 42 grid cells of one descriptor, one beat per cycle while grid_stall
// is low, into a registered output.
// ----------------------------------------------------------------------------
module mcg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop,
    input  mcg_pkg::mcg_desc_t pop_desc,
    output logic               grid_valid,
    input  logic               grid_stall,
    output mcg_pkg::mcg_grid_t grid
);

    localparam int K_W = $clog2(mcg_pkg::GRID_CELLS);
    localparam logic [K_W-1:0] K_LAST   = K_W'(mcg_pkg::GRID_CELLS - 1);
    localparam logic [2:0]     COL_LAST = 3'(mcg_pkg::GRID_COLS - 1);

    logic               active_reg, active_next;
    mcg_pkg::mcg_desc_t desc_reg;
    logic [K_W-1:0]     k_reg;
    logic [2:0]         row_reg, col_reg;
    logic               out_valid_reg, out_valid_next;
    mcg_pkg::mcg_grid_t out_reg;

    logic       out_adv, emit, last;
    logic [K_W:0] diff;
    logic [4:0] day;

    assign out_adv = !out_valid_reg || !grid_stall;
    assign emit    = active_reg && out_adv;
    assign last    = (k_reg == K_LAST);
    assign pop     = pop_valid && (!active_reg || (emit && last));

    always_comb
    begin
        diff = {1'b0, k_reg} - (K_W+1)'(desc_reg.first_col);
        if ((k_reg >= K_W'(desc_reg.first_col)) && (diff < (K_W+1)'(desc_reg.month_len)))
        begin
            day = 5'(diff + (K_W+1)'(1));
        end
        else
        begin
            day = 5'd0;
        end

        active_next = active_reg;
        if (pop)
        begin
            active_next = 1'b1;
        end
        else if (emit && last)
        begin
            active_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_adv)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                k_reg   <= '0;
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (emit)
            begin
                k_reg <= k_reg + K_W'(1);
                if (col_reg == COL_LAST)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 3'd1;
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= pop_desc;
        end
        if (emit)
        begin
            out_reg.grid_row     <= row_reg;
            out_reg.grid_column  <= col_reg;
            out_reg.day_of_month <= day;
            out_reg.last_cell    <= last;
        end
    end

    assign grid_valid = out_valid_reg;
    assign grid       = out_reg;

endmodule
